[rtl/nfp_pkg.sv]
// Shared types and constants of the navigation frame parser.
// Used by the parser core, the top level and the testbench.
package nfp_pkg;

    localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR2 = 8'h62;

    localparam logic [2:0] REG_NAV_CLASS    = 3'd0;
    localparam logic [2:0] REG_ID_POSITION  = 3'd1;
    localparam logic [2:0] REG_ID_SOLUTION  = 3'd2;
    localparam logic [2:0] REG_ID_VELOCITY  = 3'd3;
    localparam logic [2:0] REG_CAP_POSITION = 3'd4;
    localparam logic [2:0] REG_CAP_SOLUTION = 3'd5;
    localparam logic [2:0] REG_CAP_VELOCITY = 3'd6;

    localparam logic [1:0] ST_INVALID   = 2'd0;
    localparam logic [1:0] ST_NEW       = 2'd1;
    localparam logic [1:0] ST_PROCESSED = 2'd2;

    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_SOLUTION = 2'd1;
    localparam logic [1:0] KIND_VELOCITY = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_BYTE    = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_BADSUM  = 3'd3;
    localparam logic [2:0] EV_OVERRUN = 3'd4;
    localparam logic [2:0] EV_BUSY    = 3'd5;
    localparam logic [2:0] EV_RELEASE = 3'd6;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_SYNC1 = 9'b000000010,
        PH_SYNC2 = 9'b000000100,
        PH_CLASS = 9'b000001000,
        PH_LEN1  = 9'b000010000,
        PH_LEN2  = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CKA   = 9'b010000000,
        PH_CKB   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [7:0] nav_class;
        logic [7:0] id_position;
        logic [7:0] id_solution;
        logic [7:0] id_velocity;
        logic [5:0] cap_position;
        logic [5:0] cap_solution;
        logic [5:0] cap_velocity;
    } cfg_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] kind;
        logic [5:0] byte_offset;
        logic [7:0] payload_byte;
        logic [1:0] status_position;
        logic [1:0] status_solution;
        logic [1:0] status_velocity;
    } res_t;

endpackage

[rtl/nfp_if.sv]
// Valid/ready channel interfaces of the navigation frame parser.
// One carries received words in, the other carries result words out.
interface nfp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface nfp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [1:0] kind;
    logic [5:0] byte_offset;
    logic [7:0] payload_byte;
    logic [1:0] status_position;
    logic [1:0] status_solution;
    logic [1:0] status_velocity;

    modport source (
        output valid, output event_res, output kind, output byte_offset,
        output payload_byte, output status_position, output status_solution,
        output status_velocity, input ready
    );
    modport sink (
        input valid, input event_res, input kind, input byte_offset,
        input payload_byte, input status_position, input status_solution,
        input status_velocity, output ready
    );
endinterface

[rtl/nav_frame_parser_fletcher.sv]
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the parser state register is the only loop.
// Input ready stays high while the output register is empty or being drained.
// Reset (rst_n low, asynchronous) clears the parser to idle, all buffer statuses
// to invalid, the output register to empty and the registers to their defaults.
module nav_frame_parser_fletcher
    import nfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 63
)
(
    input  logic            clk,
    input  logic            rst_n,
    nfp_in_if.sink          in_ch,
    nfp_out_if.source       out_ch,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic in_accept;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nav_class <= 8'd1;
            cfg_reg.id_position <= 8'd2;
            cfg_reg.id_solution <= 8'd6;
            cfg_reg.id_velocity <= 8'd18;
            cfg_reg.cap_position <= 6'd28;
            cfg_reg.cap_solution <= 6'd52;
            cfg_reg.cap_velocity <= 6'd36;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NAV_CLASS:    cfg_reg.nav_class <= cfg_data;
                REG_ID_POSITION:  cfg_reg.id_position <= cfg_data;
                REG_ID_SOLUTION:  cfg_reg.id_solution <= cfg_data;
                REG_ID_VELOCITY:  cfg_reg.id_velocity <= cfg_data;
                REG_CAP_POSITION: cfg_reg.cap_position <= cfg_data[5:0];
                REG_CAP_SOLUTION: cfg_reg.cap_solution <= cfg_data[5:0];
                REG_CAP_VELOCITY: cfg_reg.cap_velocity <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    nfp_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_accept),
        .cmd     (in_ch.cmd),
        .rx_byte (in_ch.rx_byte),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.event_res = res_reg.event_res;
    assign out_ch.kind = res_reg.kind;
    assign out_ch.byte_offset = res_reg.byte_offset;
    assign out_ch.payload_byte = res_reg.payload_byte;
    assign out_ch.status_position = res_reg.status_position;
    assign out_ch.status_solution = res_reg.status_solution;
    assign out_ch.status_velocity = res_reg.status_velocity;

endmodule

[rtl/nfp_core.sv]
// Frame parser state, Fletcher checksum and buffer status tracking.
// Depends on nfp_pkg; steps once for every accepted word.
module nfp_core
    import nfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       cmd,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output res_t       res
);

    phase_t          phase_reg, phase_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      sa_reg, sa_next;
    logic [7:0]      sb_reg, sb_next;
    logic [1:0]      kind_reg, kind_next;
    logic [5:0]      off_reg, off_next;
    logic [2:0][1:0] status_reg, status_next;

    logic [2:0]  kind_sel;
    logic [1:0]  cur_status;
    logic [5:0]  cap_raw;
    logic [5:0]  cap_eff;
    logic [7:0]  sa_add, sb_add;
    logic [7:0]  sa_cls, sb_cls;
    logic [2:0]  ev;
    logic [5:0]  off_out;
    logic [7:0]  pb_out;

    always_comb
    begin
        kind_sel = 3'b000;
        cur_status = status_reg[2];
        cap_raw = cfg.cap_velocity;
        unique case (kind_reg)
            KIND_POSITION:
            begin
                kind_sel = 3'b001;
                cur_status = status_reg[0];
                cap_raw = cfg.cap_position;
            end
            KIND_SOLUTION:
            begin
                kind_sel = 3'b010;
                cur_status = status_reg[1];
                cap_raw = cfg.cap_solution;
            end
            default:
            begin
                kind_sel = 3'b100;
            end
        endcase
    end

    assign cap_eff = ({2'b00, cap_raw} > 8'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : cap_raw;

    assign sa_add = sa_reg + rx_byte;
    assign sb_add = sb_reg + sa_add;
    // The checksum restarts at the id byte with the class byte already folded in.
    assign sa_cls = cfg.nav_class + rx_byte;
    assign sb_cls = cfg.nav_class + sa_cls;

    always_comb
    begin
        phase_next = phase_reg;
        len_next = len_reg;
        sa_next = sa_reg;
        sb_next = sb_reg;
        kind_next = kind_reg;
        off_next = off_reg;
        status_next = status_reg;
        ev = EV_NONE;
        off_out = 6'd0;
        pb_out = 8'd0;

        if (cmd)
        begin
            status_next = {3{ST_PROCESSED}};
            ev = EV_RELEASE;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = (rx_byte == SYNC_CHAR1) ? PH_SYNC1 : PH_IDLE;
                end
                PH_SYNC1:
                begin
                    phase_next = (rx_byte == SYNC_CHAR2) ? PH_SYNC2 : PH_IDLE;
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == cfg.nav_class) ? PH_CLASS : PH_IDLE;
                end
                PH_CLASS:
                begin
                    phase_next = PH_LEN1;
                    sa_next = sa_cls;
                    sb_next = sb_cls;
                    if (rx_byte == cfg.id_position)
                    begin
                        kind_next = KIND_POSITION;
                    end
                    else if (rx_byte == cfg.id_solution)
                    begin
                        kind_next = KIND_SOLUTION;
                    end
                    else if (rx_byte == cfg.id_velocity)
                    begin
                        kind_next = KIND_VELOCITY;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        sa_next = sa_reg;
                        sb_next = sb_reg;
                    end
                end
                PH_LEN1:
                begin
                    len_next = {8'd0, rx_byte};
                    sa_next = sa_add;
                    sb_next = sb_add;
                    phase_next = PH_LEN2;
                end
                PH_LEN2:
                begin
                    len_next = {rx_byte, len_reg[7:0]};
                    sa_next = sa_add;
                    sb_next = sb_add;
                    if (cur_status == ST_NEW)
                    begin
                        ev = EV_BUSY;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (kind_sel[i])
                            begin
                                status_next[i] = ST_INVALID;
                            end
                        end
                        off_next = 6'd0;
                        phase_next = ({rx_byte, len_reg[7:0]} == 16'd0) ? PH_CKA : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (off_reg < cap_eff)
                    begin
                        ev = EV_BYTE;
                        off_out = off_reg;
                        pb_out = rx_byte;
                        sa_next = sa_add;
                        sb_next = sb_add;
                        off_next = off_reg + 6'd1;
                        len_next = len_reg - 16'd1;
                        if (len_reg == 16'd1)
                        begin
                            phase_next = PH_CKA;
                        end
                    end
                    else
                    begin
                        ev = EV_OVERRUN;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CKA:
                begin
                    if (rx_byte == sa_reg)
                    begin
                        phase_next = PH_CKB;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (kind_sel[i])
                            begin
                                status_next[i] = ST_INVALID;
                            end
                        end
                        ev = EV_BADSUM;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CKB:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (kind_sel[i])
                        begin
                            status_next[i] = (rx_byte == sb_reg) ? ST_NEW : ST_INVALID;
                        end
                    end
                    ev = (rx_byte == sb_reg) ? EV_GOOD : EV_BADSUM;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg <= 16'd0;
            sa_reg <= 8'd0;
            sb_reg <= 8'd0;
            kind_reg <= KIND_POSITION;
            off_reg <= 6'd0;
            status_reg <= {3{ST_INVALID}};
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            len_reg <= len_next;
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            kind_reg <= kind_next;
            off_reg <= off_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        res.event_res = ev;
        res.kind = (ev >= EV_BYTE && ev <= EV_BUSY) ? kind_reg : 2'd0;
        res.byte_offset = off_out;
        res.payload_byte = pb_out;
        res.status_position = status_next[0];
        res.status_solution = status_next[1];
        res.status_velocity = status_next[2];
    end

`ifndef SYNTHESIS
    // A payload phase always has at least one byte still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> len_reg != 16'd0)
        else $error("payload phase entered with zero remaining length");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cmd |=> status_reg == {3{ST_PROCESSED}})
        else $error("release did not mark all buffers processed");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !cmd && phase_reg == PH_CKB && rx_byte == sb_reg
        |=> status_reg[$past(kind_reg)] == ST_NEW)
        else $error("good frame did not mark its buffer new");
`endif

endmodule

[tb/sv/tb_nav_frame_parser_fletcher.sv]
// Self-checking testbench of the navigation frame parser: valid and damaged frames,
// busy buffers, releases and register settings, with every result word checked.
// Depends on nfp_pkg, the nfp_in_if/nfp_out_if interfaces and nav_frame_parser_fletcher.
module tb_nav_frame_parser_fletcher;
    import nfp_pkg::*;

    localparam int MAX_PAYLOAD     = 63;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int WORDS_PER_PHASE = 200;
    localparam int LAST_SETTING    = 5;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 200;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef enum int { FR_CLEAN, FR_BAD_A, FR_BAD_B, FR_HEADER_ONLY } frame_damage_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    nfp_in_if  in_ch ();
    nfp_out_if out_ch ();

    nav_frame_parser_fletcher #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rx_word_t    pending_words[$];
    res_t        expected_events[$];
    int unsigned words_queued;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // Parser model state and its copy of the registers.
    cfg_t        active_cfg;
    phase_t      model_phase;
    logic [15:0] model_remaining;
    logic [7:0]  model_sum_a;
    logic [7:0]  model_sum_b;
    logic [1:0]  model_kind;
    logic [5:0]  model_offset;
    logic [1:0]  model_status [3];

    rx_word_t    next_word;
    res_t        want_word;
    int unsigned burst_left;
    int unsigned gap_left;
    logic [15:0] stall_mask;
    logic [5:0]  stall_step;
    int unsigned hold_left;
    logic        hold_done;

    function automatic logic [5:0] capacity_of(logic [1:0] k);
        logic [5:0] c;
        case (k)
            KIND_POSITION: c = active_cfg.cap_position;
            KIND_SOLUTION: c = active_cfg.cap_solution;
            default:       c = active_cfg.cap_velocity;
        endcase
        return (c > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : c;
    endfunction

    function automatic void fletcher_add(logic [7:0] b);
        model_sum_a = model_sum_a + b;
        model_sum_b = model_sum_b + model_sum_a;
    endfunction

    function automatic res_t parse_rx_word(logic cmd, logic [7:0] b);
        res_t       r;
        logic [1:0] k;
        logic       hit;
        r   = '0;
        hit = 1'b1;
        k   = (model_kind > KIND_VELOCITY) ? KIND_POSITION : model_kind;
        if (cmd)
        begin
            foreach (model_status[i]) model_status[i] = ST_PROCESSED;
            r.event_res = EV_RELEASE;
        end
        else
        begin
            case (model_phase)
                PH_IDLE:  model_phase = (b == SYNC_CHAR1) ? PH_SYNC1 : PH_IDLE;
                PH_SYNC1: model_phase = (b == SYNC_CHAR2) ? PH_SYNC2 : PH_IDLE;
                PH_SYNC2: model_phase = (b == active_cfg.nav_class) ? PH_CLASS : PH_IDLE;
                PH_CLASS:
                begin
                    // Position wins over solution, and solution over velocity.
                    if (b == active_cfg.id_position) model_kind = KIND_POSITION;
                    else if (b == active_cfg.id_solution) model_kind = KIND_SOLUTION;
                    else if (b == active_cfg.id_velocity) model_kind = KIND_VELOCITY;
                    else hit = 1'b0;
                    if (hit)
                    begin
                        model_sum_a = '0;
                        model_sum_b = '0;
                        fletcher_add(active_cfg.nav_class);
                        fletcher_add(b);
                        model_phase = PH_LEN1;
                    end
                    else
                    begin
                        model_phase = PH_IDLE;
                    end
                end
                PH_LEN1:
                begin
                    model_remaining = {8'h00, b};
                    fletcher_add(b);
                    model_phase = PH_LEN2;
                end
                PH_LEN2:
                begin
                    model_remaining[15:8] = b;
                    fletcher_add(b);
                    if (model_status[k] == ST_NEW)
                    begin
                        r.event_res = EV_BUSY;
                        model_phase = PH_IDLE;
                    end
                    else
                    begin
                        model_status[k] = ST_INVALID;
                        model_offset    = '0;
                        model_phase     = (model_remaining == 16'd0) ? PH_CKA : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (model_offset < capacity_of(k))
                    begin
                        r.event_res    = EV_BYTE;
                        r.byte_offset  = model_offset;
                        r.payload_byte = b;
                        fletcher_add(b);
                        model_offset    = model_offset + 6'd1;
                        model_remaining = model_remaining - 16'd1;
                        if (model_remaining == 16'd0) model_phase = PH_CKA;
                    end
                    else
                    begin
                        r.event_res = EV_OVERRUN;
                        model_phase = PH_IDLE;
                    end
                end
                PH_CKA:
                begin
                    if (b == model_sum_a)
                    begin
                        model_phase = PH_CKB;
                    end
                    else
                    begin
                        model_status[k] = ST_INVALID;
                        r.event_res     = EV_BADSUM;
                        model_phase     = PH_IDLE;
                    end
                end
                PH_CKB:
                begin
                    if (b == model_sum_b)
                    begin
                        model_status[k] = ST_NEW;
                        r.event_res     = EV_GOOD;
                    end
                    else
                    begin
                        model_status[k] = ST_INVALID;
                        r.event_res     = EV_BADSUM;
                    end
                    model_phase = PH_IDLE;
                end
                default: model_phase = PH_IDLE;
            endcase
        end
        if (r.event_res >= EV_BYTE && r.event_res <= EV_BUSY) r.kind = k;
        r.status_position = model_status[KIND_POSITION];
        r.status_solution = model_status[KIND_SOLUTION];
        r.status_velocity = model_status[KIND_VELOCITY];
        return r;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_byte(logic [7:0] b);
        pending_words.push_back('{1'b0, b});
        words_queued++;
    endtask

    task automatic queue_release(logic [7:0] b);
        pending_words.push_back('{1'b1, b});
        words_queued++;
    endtask

    // Builds one frame for buffer k. A length beyond the capacity sends one byte
    // past it, since the parser gives up at that byte; a checksum follows only when the length is one past it.
    task automatic queue_frame(logic [1:0] k, logic [15:0] len, frame_damage_t damage);
        logic [7:0]  id;
        logic [7:0]  sa;
        logic [7:0]  sb;
        logic [7:0]  b;
        int unsigned n;
        case (k)
            KIND_POSITION: id = active_cfg.id_position;
            KIND_SOLUTION: id = active_cfg.id_solution;
            default:       id = active_cfg.id_velocity;
        endcase
        n  = (len > capacity_of(k)) ? capacity_of(k) + 1 : len;
        sa = active_cfg.nav_class;
        sb = sa;
        sa += id;
        sb += sa;
        sa += len[7:0];
        sb += sa;
        sa += len[15:8];
        sb += sa;
        queue_byte(SYNC_CHAR1);
        queue_byte(SYNC_CHAR2);
        queue_byte(active_cfg.nav_class);
        queue_byte(id);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        if (damage != FR_HEADER_ONLY)
        begin
            for (int i = 0; i < n; i++)
            begin
                // A release in the middle of a frame must leave the parse untouched.
                if ($urandom_range(0, 39) == 0) queue_release(8'($urandom));
                b = 8'($urandom);
                queue_byte(b);
                sa += b;
                sb += sa;
            end
            if (n == len)
            begin
                queue_byte((damage == FR_BAD_A) ? sa ^ 8'($urandom_range(1, 255)) : sa);
                queue_byte((damage == FR_BAD_B) ? sb ^ 8'($urandom_range(1, 255)) : sb);
            end
        end
    endtask

    task automatic queue_random_traffic(int unsigned count);
        int unsigned   stop_at;
        int unsigned   pick;
        int unsigned   cap;
        logic [1:0]    k;
        logic [15:0]   len;
        logic [7:0]    b;
        frame_damage_t damage;
        stop_at = words_queued + count;
        while (words_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            k    = 2'($urandom_range(0, 2));
            cap  = capacity_of(k);
            if (pick < 22)
            begin
                queue_release(8'($urandom));
            end
            else if (pick < 84)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = 16'($urandom_range(0, (cap < 8) ? cap : 8));
                    5, 6, 7:       len = 16'($urandom_range(0, cap));
                    8:             len = 16'(cap + 1 + $urandom_range(0, 3));
                    default:       len = {8'($urandom_range(1, 255)), 8'($urandom)};
                endcase
                case ($urandom_range(0, 9))
                    0:       damage = FR_BAD_A;
                    1:       damage = FR_BAD_B;
                    default: damage = FR_CLEAN;
                endcase
                queue_frame(k, len, damage);
            end
            else if (pick < 88)
            begin
                queue_frame(k, 16'($urandom), FR_HEADER_ONLY);
            end
            else if (pick < 91)
            begin
                queue_byte(SYNC_CHAR1);
                do b = 8'($urandom); while (b == SYNC_CHAR2);
                queue_byte(b);
            end
            else if (pick < 94)
            begin
                queue_byte(SYNC_CHAR1);
                queue_byte(SYNC_CHAR2);
                queue_byte(active_cfg.nav_class ^ 8'($urandom_range(1, 255)));
            end
            else if (pick < 97)
            begin
                queue_byte(SYNC_CHAR1);
                queue_byte(SYNC_CHAR2);
                queue_byte(active_cfg.nav_class);
                do b = 8'($urandom);
                while (b == active_cfg.id_position || b == active_cfg.id_solution ||
                       b == active_cfg.id_velocity);
                queue_byte(b);
            end
            else
            begin
                // Line noise is not counted as traffic.
                repeat ($urandom_range(1, 6)) pending_words.push_back('{1'b0, 8'($urandom)});
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic load_setting(int s);
        cfg_t nxt;
        case (s)
            1:
            begin
                nxt = cfg_t'({$urandom, $urandom});
            end
            2:       nxt = '{8'd0, 8'd0, 8'd0, 8'd0, 6'd0, 6'd63, 6'd63};
            3:       nxt = '{8'd255, 8'd255, 8'd255, 8'd1, 6'd63, 6'd1, 6'd0};
            4:
            begin
                nxt.nav_class    = 8'($urandom);
                nxt.id_position  = 8'($urandom);
                nxt.id_solution  = nxt.id_position ^ 8'($urandom_range(1, 255));
                nxt.id_velocity  = nxt.id_solution;
                nxt.cap_position = 6'($urandom_range(1, 12));
                nxt.cap_solution = 6'($urandom_range(1, 12));
                nxt.cap_velocity = 6'($urandom_range(1, 12));
            end
            default: nxt = '{8'd1, 8'd2, 8'd6, 8'd18, 6'd28, 6'd52, 6'd36};
        endcase
        write_reg(REG_NAV_CLASS, nxt.nav_class);
        write_reg(REG_ID_POSITION, nxt.id_position);
        write_reg(REG_ID_SOLUTION, nxt.id_solution);
        write_reg(REG_ID_VELOCITY, nxt.id_velocity);
        // The upper bits of a capacity write are junk that the block must drop.
        write_reg(REG_CAP_POSITION, {2'($urandom), nxt.cap_position});
        write_reg(REG_CAP_SOLUTION, {2'($urandom), nxt.cap_solution});
        write_reg(REG_CAP_VELOCITY, {2'($urandom), nxt.cap_velocity});
        if (s == 1) write_reg(REG_UNUSED, 8'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_events.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: bursts of random length with random gaps, some bursts very long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.cmd     <= 1'b0;
            in_ch.rx_byte <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left != 0)
            begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end
            else if (pending_words.size() != 0)
            begin
                next_word      = pending_words.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.cmd     <= next_word.cmd;
                in_ch.rx_byte <= next_word.rx_byte;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: a stall mask that changes each time the step counter wraps, plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mask   <= '1;
            stall_step   <= '0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            hold_done    <= 1'b1;
        end
        else
        begin
            out_ch.ready <= stall_mask[stall_step[3:0]];
            stall_step   <= stall_step + 6'd1;
            if (stall_step == 6'd63)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_mask <= '1;
                    1:       stall_mask <= 16'($urandom) & 16'($urandom);
                    default: stall_mask <= 16'($urandom);
                endcase
            end
        end
    end

    // Monitor: tracks register writes, predicts each accepted word and checks results.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            active_cfg      = '{8'd1, 8'd2, 8'd6, 8'd18, 6'd28, 6'd52, 6'd36};
            model_phase     = PH_IDLE;
            model_remaining = '0;
            model_sum_a     = '0;
            model_sum_b     = '0;
            model_kind      = KIND_POSITION;
            model_offset    = '0;
            foreach (model_status[i]) model_status[i] = ST_INVALID;
            results_seen   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NAV_CLASS:    active_cfg.nav_class    = cfg_data;
                    REG_ID_POSITION:  active_cfg.id_position  = cfg_data;
                    REG_ID_SOLUTION:  active_cfg.id_solution  = cfg_data;
                    REG_ID_VELOCITY:  active_cfg.id_velocity  = cfg_data;
                    REG_CAP_POSITION: active_cfg.cap_position = cfg_data[5:0];
                    REG_CAP_SOLUTION: active_cfg.cap_solution = cfg_data[5:0];
                    REG_CAP_VELOCITY: active_cfg.cap_velocity = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_events.size() == 0)
                begin
                    $error("result word with no pending expectation: event_res %0d",
                           out_ch.event_res);
                    mismatch_count++;
                end
                else
                begin
                    want_word = expected_events.pop_front();
                    check_field("event_res", 8'(want_word.event_res), 8'(out_ch.event_res));
                    check_field("kind", 8'(want_word.kind), 8'(out_ch.kind));
                    check_field("byte_offset", 8'(want_word.byte_offset),
                                8'(out_ch.byte_offset));
                    check_field("payload_byte", want_word.payload_byte, out_ch.payload_byte);
                    check_field("status_position", 8'(want_word.status_position),
                                8'(out_ch.status_position));
                    check_field("status_solution", 8'(want_word.status_solution),
                                8'(out_ch.status_solution));
                    check_field("status_velocity", 8'(want_word.status_velocity),
                                8'(out_ch.status_velocity));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_events.push_back(parse_rx_word(in_ch.cmd, in_ch.rx_byte));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        do @(negedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Release first, then a good empty frame, a frame hitting the busy buffer
        // and a one-byte frame to another buffer.
        queue_release(8'hFF);
        queue_frame(KIND_POSITION, 16'd0, FR_CLEAN);
        queue_frame(KIND_POSITION, 16'd0, FR_HEADER_ONLY);
        queue_frame(KIND_VELOCITY, 16'd1, FR_CLEAN);

        for (int s = 0; s <= LAST_SETTING; s++)
        begin
            if (s != 0)
            begin
                wait_drained();
                load_setting(s);
                @(negedge clk);
            end
            queue_random_traffic(WORDS_PER_PHASE);
        end
        wait_drained();

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
